// File: rtl/core/ssr_pkg.sv
// Shared types and constants for the streaming substring replace core.
`timescale 1ns / 1ps

package ssr_pkg;

    // Window storage is never larger than this many bytes.
    localparam int HW_BYTES = 8;
    // Counts 0..HW_BYTES.
    localparam int CNT_W    = 4;
    // Indexes 0..HW_BYTES-1.
    localparam int IDX_W    = 3;

    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REPL
    } t_state;

    // Control broadcast to every window cell.
    typedef struct packed {
        logic             load;
        logic             shift;
        logic [CNT_W-1:0] wr_idx;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

endpackage

// File: rtl/core/stream_substring_replace_core.sv
// Top level of the streaming substring replace core.
`timescale 1ns / 1ps
// Pass-through: an accepted input byte goes straight into the output register. With a pattern
// the byte is loaded into the window cells and evaluated in ST_EVAL; window bytes are given from
// the front, and a full match passes to ST_REPL for the replacement. Pass-through is 1 byte per
// cycle while the output register is free; with a pattern a new byte is taken only in ST_IDLE.
// Synchronous active-low reset clears control and configuration; window cells undefined.

module stream_substring_replace_core #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_text_done
);

    // Number of window cells and usable replacement bytes.
    localparam int W  = (MAX_PATTERN < ssr_pkg::HW_BYTES) ? MAX_PATTERN : ssr_pkg::HW_BYTES;
    localparam int RW = (MAX_REPLACEMENT < ssr_pkg::HW_BYTES) ?
                        MAX_REPLACEMENT : ssr_pkg::HW_BYTES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [63:0]              r_pat;
    logic [ssr_pkg::CNT_W-1:0] r_plen;
    logic [63:0]              r_rep;
    logic [ssr_pkg::CNT_W-1:0] r_rlen;
    logic                     w_pat_wr;

    assign w_pat_wr = i_cfg_wr_en &&
        ((i_cfg_index == ssr_pkg::CFG_PATTERN_BYTES) ||
         (i_cfg_index == ssr_pkg::CFG_PATTERN_LENGTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (ssr_pkg::t_cfg_idx'(i_cfg_index))
                ssr_pkg::CFG_PATTERN_BYTES:      r_pat  <= i_cfg_data;
                ssr_pkg::CFG_PATTERN_LENGTH:     r_plen <= i_cfg_data[ssr_pkg::CNT_W-1:0];
                ssr_pkg::CFG_REPLACEMENT_BYTES:  r_rep  <= i_cfg_data;
                ssr_pkg::CFG_REPLACEMENT_LENGTH: r_rlen <= i_cfg_data[ssr_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Lengths saturate at the hardware limits.
    logic [ssr_pkg::CNT_W-1:0] w_plen;
    logic [ssr_pkg::CNT_W-1:0] w_rlen;

    assign w_plen = (r_plen > ssr_pkg::CNT_W'(W))  ? ssr_pkg::CNT_W'(W)  : r_plen;
    assign w_rlen = (r_rlen > ssr_pkg::CNT_W'(RW)) ? ssr_pkg::CNT_W'(RW) : r_rlen;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    ssr_pkg::t_state           r_state, n_state;
    logic [ssr_pkg::CNT_W-1:0] r_wc, n_wc;        // bytes held in the window
    logic [ssr_pkg::IDX_W-1:0] r_cnt, n_cnt;      // replacement byte index
    logic                      r_last, n_last;    // item carries end of text
    logic                      r_emitted, n_emitted;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_bvalid;
    logic       r_out_done;

    logic       w_slot_free;
    logic       w_in_fire;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ssr_pkg::ST_IDLE) && ((w_plen != '0) || w_slot_free);
    assign w_in_fire   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Window cell chain
    // ------------------------------------------------------------------
    ssr_pkg::t_cell_ctl        w_ctl;
    logic [7:0]                w_cell_byte [W];
    logic [W-1:0]              w_cell_ok;
    logic                      w_prefix;
    logic [ssr_pkg::CNT_W-1:0] w_wr_idx;
    logic                      w_load;
    logic                      w_shift;

    // A stale window as long as the pattern restarts from the first cell.
    assign w_wr_idx = (r_wc >= w_plen) ? '0 : r_wc;

    assign w_ctl.load   = w_load;
    assign w_ctl.shift  = w_shift;
    assign w_ctl.wr_idx = w_wr_idx;
    assign w_ctl.count  = r_wc;

    for (genvar g = 0; g < W; g++) begin : g_cell
        logic [7:0] w_next;
        if (g < W - 1) begin : g_mid
            assign w_next = w_cell_byte[g+1];
        end else begin : g_end
            assign w_next = 8'h00;
        end
        ssr_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_in_byte   (i_in_byte),
            .i_next_byte (w_next),
            .i_pat_byte  (r_pat[8*g +: 8]),
            .o_byte      (w_cell_byte[g]),
            .o_ok        (w_cell_ok[g])
        );
    end

    assign w_prefix = &w_cell_ok;

    logic w_full_match;
    logic w_front_out;
    logic w_need_marker;
    logic w_rep_last;

    assign w_full_match  = (r_wc != '0) && (r_wc == w_plen) && w_prefix;
    // Drop the oldest byte while the window is no pattern prefix, or to flush at end.
    assign w_front_out   = (r_wc != '0) && (!w_prefix || r_last);
    assign w_need_marker = r_last && !r_emitted;
    assign w_rep_last    = ({1'b0, r_cnt} == (w_rlen - ssr_pkg::CNT_W'(1)));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssr_pkg::ST_IDLE: begin
                if (w_in_fire && (w_plen != '0)) begin
                    n_state = ssr_pkg::ST_EVAL;
                end
            end
            ssr_pkg::ST_EVAL: begin
                priority if (w_full_match) begin
                    n_state = ssr_pkg::ST_REPL;
                end else if (w_front_out) begin
                    n_state = ssr_pkg::ST_EVAL;
                end else if (w_need_marker) begin
                    if (w_slot_free) begin
                        n_state = ssr_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = ssr_pkg::ST_IDLE;
                end
            end
            ssr_pkg::ST_REPL: begin
                if (w_rlen == '0) begin
                    n_state = ssr_pkg::ST_EVAL;
                end else if (w_slot_free && w_rep_last) begin
                    n_state = ssr_pkg::ST_EVAL;
                end
            end
            default: n_state = ssr_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control and emission
    // ------------------------------------------------------------------
    logic       w_emit;
    logic [7:0] w_e_byte;
    logic       w_e_bvalid;
    logic       w_e_done;

    always_comb begin
        w_emit     = 1'b0;
        w_e_byte   = 8'h00;
        w_e_bvalid = 1'b1;
        w_e_done   = 1'b0;
        w_load     = 1'b0;
        w_shift    = 1'b0;
        n_wc       = r_wc;
        n_cnt      = r_cnt;
        n_last     = r_last;
        n_emitted  = r_emitted;
        unique case (r_state)
            ssr_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    n_last    = i_end_of_text;
                    n_emitted = 1'b0;
                    if (w_plen == '0) begin
                        // pass-through
                        w_emit   = 1'b1;
                        w_e_byte = i_in_byte;
                        w_e_done = i_end_of_text;
                        n_wc     = '0;
                    end else begin
                        w_load = 1'b1;
                        n_wc   = w_wr_idx + ssr_pkg::CNT_W'(1);
                    end
                end
            end
            ssr_pkg::ST_EVAL: begin
                priority if (w_full_match) begin
                    n_wc  = '0;
                    n_cnt = '0;
                end else if (w_front_out) begin
                    if (w_slot_free) begin
                        w_emit    = 1'b1;
                        w_e_byte  = w_cell_byte[0];
                        w_e_done  = r_last && (r_wc == ssr_pkg::CNT_W'(1));
                        w_shift   = 1'b1;
                        n_wc      = r_wc - ssr_pkg::CNT_W'(1);
                        n_emitted = 1'b1;
                    end
                end else if (w_need_marker) begin
                    if (w_slot_free) begin
                        // end of text with nothing to give: bare marker
                        w_emit     = 1'b1;
                        w_e_bvalid = 1'b0;
                        w_e_done   = 1'b1;
                        n_emitted  = 1'b1;
                    end
                end else begin
                    n_emitted = r_emitted;
                end
            end
            ssr_pkg::ST_REPL: begin
                if ((w_rlen != '0) && w_slot_free) begin
                    w_emit    = 1'b1;
                    w_e_byte  = r_rep[{r_cnt, 3'b000} +: 8];
                    w_e_done  = r_last && w_rep_last;
                    n_emitted = 1'b1;
                    if (!w_rep_last) begin
                        n_cnt = r_cnt + ssr_pkg::IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssr_pkg::ST_IDLE;
            r_wc      <= '0;
            r_cnt     <= '0;
            r_last    <= 1'b0;
            r_emitted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_last    <= n_last;
            r_emitted <= n_emitted;
            // a new pattern invalidates what the window holds
            r_wc      <= w_pat_wr ? '0 : n_wc;
        end
    end

    // Output register: one result waits here while the chain keeps working.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte   <= w_e_byte;
            r_out_bvalid <= w_e_bvalid;
            r_out_done   <= w_e_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_out_bvalid;
    assign o_text_done  = r_out_done;

`ifndef NO_ASSERTIONS
    a_wc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= ssr_pkg::CNT_W'(W))
        else $error("window count exceeds cell count");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (w_plen != '0) && !i_cfg_wr_en) |=> (r_state == ssr_pkg::ST_EVAL))
        else $error("accepted byte not evaluated");

    a_repl_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssr_pkg::ST_REPL) |-> (r_wc == '0))
        else $error("window not emptied during replacement");

    a_marker_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_bvalid) |-> r_out_done)
        else $error("bare marker without text_done");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_slot_free)
        else $error("result emitted into a full output register");
`endif

endmodule

// File: rtl/core/ssr_cell.sv
// One window cell: holds one byte, compares it with its pattern byte.
`timescale 1ns / 1ps

module ssr_cell #(
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  ssr_pkg::t_cell_ctl   i_ctl,
    input  logic [7:0]           i_in_byte,
    input  logic [7:0]           i_next_byte,
    input  logic [7:0]           i_pat_byte,
    output logic [7:0]           o_byte,
    output logic                 o_ok
);

    logic [7:0] r_byte;

    // Shift toward the front of the window, or capture the new byte.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_next_byte;
        end else if (i_ctl.load && (i_ctl.wr_idx == ssr_pkg::CNT_W'(IDX))) begin
            r_byte <= i_in_byte;
        end
    end

    assign o_byte = r_byte;
    // Empty cells never break the prefix.
    assign o_ok   = (ssr_pkg::CNT_W'(IDX) >= i_ctl.count) || (r_byte == i_pat_byte);

endmodule
